FILE: hdl/nfcm_pkg.sv
// Shared types, band thresholds and the fractional scale helper for the
// noise false-color mapper. No dependencies.
`default_nettype none

package nfcm_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned ModeW   = 3;

  typedef enum logic [ModeW-1:0] {
    MODE_GRAY    = 3'd0,
    MODE_RGB     = 3'd1,
    MODE_RGBA    = 3'd2,
    MODE_HEIGHT  = 3'd3,
    MODE_TERRAIN = 3'd4
  } mode_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             mono;
  } pixel_t;

  // Heightmap thresholds: 0.3, 0.5, 0.7, 0.9 in Q0.16
  localparam logic [SampleW-1:0] ThH1 = 16'd19661;
  localparam logic [SampleW-1:0] ThH2 = 16'd32768;
  localparam logic [SampleW-1:0] ThH3 = 16'd45875;
  localparam logic [SampleW-1:0] ThH4 = 16'd58982;
  // Terrain thresholds: 0.2, 0.4, 0.6, 0.8 in Q0.16
  localparam logic [SampleW-1:0] ThT1 = 16'd13107;
  localparam logic [SampleW-1:0] ThT2 = 16'd26214;
  localparam logic [SampleW-1:0] ThT3 = 16'd39322;
  localparam logic [SampleW-1:0] ThT4 = 16'd52429;

  // (t * k) >> 16 with t in Q0.16
  function automatic logic [ChanW-1:0] scale(input logic [SampleW-1:0] t,
                                             input logic [ChanW-1:0]   k);
    logic [SampleW+ChanW-1:0] prod;
    prod = {{ChanW{1'b0}}, t} * {{SampleW{1'b0}}, k};
    return prod[SampleW+ChanW-1:SampleW];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/noise_false_color_mapper_unit.sv
// Throughput: one beat per cycle unless stalled; the input register feeds the
// mapping logic and the pixel register, each stage advancing when the next
// one frees up.
// Reset clears the valid flags and sets the color mode to grayscale.
// Top level of the noise false-color mapper. Depends on nfcm_pkg, nfcm_map.
`default_nettype none

module noise_false_color_mapper_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [nfcm_pkg::ModeW-1:0]         cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [nfcm_pkg::SampleW-1:0] sample_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [nfcm_pkg::ChanW-1:0]              red_o,
  output logic [nfcm_pkg::ChanW-1:0]              green_o,
  output logic [nfcm_pkg::ChanW-1:0]              blue_o,
  output logic                                    mono_o
);
  import nfcm_pkg::*;

  logic [ModeW-1:0]   mode_q;
  logic               s1_valid_q;
  logic [SampleW-1:0] t_q;
  logic               out_valid_q;
  pixel_t             pix_q;
  pixel_t             pix_d;
  logic               out_busy;
  logic               s1_busy;

  assign out_busy   = out_valid_q && out_stall_i;
  assign s1_busy    = s1_valid_q && out_busy;
  assign in_stall_o = s1_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_GRAY;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // flip the sign bit: sample + 32768 as Q0.16
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_busy) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !s1_busy) begin
      t_q <= {~sample_i[SampleW-1], sample_i[SampleW-2:0]};
    end
  end

  nfcm_map u_map (
    .t_i    (t_q),
    .mode_i (mode_q),
    .pix_o  (pix_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_busy) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && !out_busy) begin
      pix_q <= pix_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = pix_q.red;
  assign green_o     = pix_q.green;
  assign blue_o      = pix_q.blue;
  assign mono_o      = pix_q.mono;

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled while a stage is empty");

  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_busy) |=> out_valid_q)
    else $error("stage one beat lost before the pixel register");

  a_in_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted sample beat lost");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !s1_valid_q) |=> !out_valid_q)
    else $error("pixel beat repeated");

  a_mono_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && mono_o) |-> (green_o == '0 && blue_o == '0))
    else $error("grayscale pixel carries color");

endmodule

`default_nettype wire

FILE: hdl/nfcm_map.sv
// Combinational color mapping of one Q0.16 level to a pixel.
// Depends on nfcm_pkg.
`default_nettype none

module nfcm_map (
  input  wire logic [nfcm_pkg::SampleW-1:0] t_i,
  input  wire logic [nfcm_pkg::ModeW-1:0]   mode_i,
  output nfcm_pkg::pixel_t                  pix_o
);
  import nfcm_pkg::*;

  always_comb begin
    pix_o = '0;
    case (mode_i)
      MODE_RGB, MODE_RGBA: begin
        pix_o.red   = scale(t_i, 8'd255);
        pix_o.green = scale(t_i, 8'd255);
        pix_o.blue  = scale(t_i, 8'd255);
      end
      MODE_HEIGHT: begin
        if (t_i < ThH1) begin
          pix_o.red   = scale(t_i, 8'd100);
          pix_o.green = scale(t_i, 8'd150);
          pix_o.blue  = 8'd255;
        end else if (t_i < ThH2) begin
          pix_o.red   = 8'd200 + scale(t_i, 8'd55);
          pix_o.green = 8'd180 + scale(t_i, 8'd75);
          pix_o.blue  = 8'd100 + scale(t_i, 8'd50);
        end else if (t_i < ThH3) begin
          pix_o.red   = scale(t_i, 8'd100);
          pix_o.green = 8'd100 + scale(t_i, 8'd155);
          pix_o.blue  = scale(t_i, 8'd50);
        end else if (t_i < ThH4) begin
          pix_o.red   = 8'd100 + scale(t_i, 8'd100);
          pix_o.green = 8'd100 + scale(t_i, 8'd100);
          pix_o.blue  = 8'd100 + scale(t_i, 8'd100);
        end else begin
          pix_o.red   = 8'd255;
          pix_o.green = 8'd255;
          pix_o.blue  = 8'd255;
        end
      end
      MODE_TERRAIN: begin
        if (t_i < ThT1) begin
          pix_o.blue  = 8'd100 + scale(t_i, 8'd100);
        end else if (t_i < ThT2) begin
          pix_o.green = 8'd50 + scale(t_i, 8'd100);
          pix_o.blue  = 8'd150 + scale(t_i, 8'd50);
        end else if (t_i < ThT3) begin
          pix_o.red   = 8'd200 + scale(t_i, 8'd55);
          pix_o.green = 8'd180 + scale(t_i, 8'd75);
          pix_o.blue  = 8'd100 + scale(t_i, 8'd50);
        end else if (t_i < ThT4) begin
          pix_o.red   = scale(t_i, 8'd50);
          pix_o.green = 8'd80 + scale(t_i, 8'd120);
          pix_o.blue  = scale(t_i, 8'd30);
        end else begin
          pix_o.red   = 8'd150 + scale(t_i, 8'd105);
          pix_o.green = 8'd150 + scale(t_i, 8'd105);
          pix_o.blue  = 8'd150 + scale(t_i, 8'd105);
        end
      end
      default: begin
        pix_o.red  = scale(t_i, 8'd255);
        pix_o.mono = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sim/noise_false_color_mapper_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for noise_false_color_mapper_unit: drives sample beats, predicts each
// pixel from the color mode and compares it field by field. Depends on nfcm_pkg.

module noise_false_color_mapper_unit_tb;
  import nfcm_pkg::*;

  localparam logic [ModeW-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [ModeW-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_RSVD7 = 3'd7;

  localparam int unsigned HgtSand    = 19661;
  localparam int unsigned HgtGrass   = 32768;
  localparam int unsigned HgtRock    = 45875;
  localparam int unsigned HgtSnow    = 58982;
  localparam int unsigned TerShallow = 13107;
  localparam int unsigned TerBeach   = 26214;
  localparam int unsigned TerForest  = 39322;
  localparam int unsigned TerPeaks   = 52429;

  localparam int PipeDepth  = 2;
  localparam int DrainLimit = 5000;
  localparam int NumPhases  = 12;
  localparam int PhaseBeats = 128;
  localparam int HoldCycles = 60;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [ModeW-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [SampleW-1:0]  sample_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ChanW-1:0]    red_o;
  logic [ChanW-1:0]    green_o;
  logic [ChanW-1:0]    blue_o;
  logic                mono_o;

  logic [SampleW-1:0]  samples_pending[$];
  pixel_t              pixels_due[$];
  logic [ModeW-1:0]    mode_shadow = MODE_GRAY;
  int unsigned         band_edges[8] = '{HgtSand, HgtGrass, HgtRock, HgtSnow,
                                         TerShallow, TerBeach, TerForest, TerPeaks};
  logic [ModeW-1:0]    mode_order[8] = '{MODE_GRAY, MODE_RGB, MODE_RGBA, MODE_HEIGHT,
                                         MODE_TERRAIN, MODE_RSVD5, MODE_RSVD6,
                                         MODE_RSVD7};
  int                  errors     = 0;
  int                  idle_pct   = 0;
  int                  send_gap   = 0;
  int                  stall_left = 0;
  int                  hold_left  = 0;
  bit                  hold_req   = 1'b0;
  bit                  in_taken   = 1'b0;

  noise_false_color_mapper_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .mono_o      (mono_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [ChanW-1:0] chan(input int unsigned base,
                                            input logic [SampleW-1:0] t,
                                            input int unsigned k);
    int unsigned tt;
    int unsigned v;
    tt = t;
    v = base + ((tt * k) >> 16);
    return v[ChanW-1:0];
  endfunction

  function automatic pixel_t map_sample(input logic [SampleW-1:0] s,
                                        input logic [ModeW-1:0] m);
    logic [SampleW-1:0] t;
    pixel_t p;
    t = s ^ 16'h8000;
    p = '0;
    case (m)
      MODE_RGB, MODE_RGBA: begin
        p.red = chan(0, t, 255);
        p.green = p.red;
        p.blue = p.red;
      end
      MODE_HEIGHT: begin
        if (t < HgtSand) begin
          p.red = chan(0, t, 100); p.green = chan(0, t, 150); p.blue = chan(255, t, 0);
        end else if (t < HgtGrass) begin
          p.red = chan(200, t, 55); p.green = chan(180, t, 75); p.blue = chan(100, t, 50);
        end else if (t < HgtRock) begin
          p.red = chan(0, t, 100); p.green = chan(100, t, 155); p.blue = chan(0, t, 50);
        end else if (t < HgtSnow) begin
          p.red = chan(100, t, 100); p.green = p.red; p.blue = p.red;
        end else begin
          p.red = chan(255, t, 0); p.green = p.red; p.blue = p.red;
        end
      end
      MODE_TERRAIN: begin
        if (t < TerShallow) begin
          p.blue = chan(100, t, 100);
        end else if (t < TerBeach) begin
          p.green = chan(50, t, 100); p.blue = chan(150, t, 50);
        end else if (t < TerForest) begin
          p.red = chan(200, t, 55); p.green = chan(180, t, 75); p.blue = chan(100, t, 50);
        end else if (t < TerPeaks) begin
          p.red = chan(0, t, 50); p.green = chan(80, t, 120); p.blue = chan(0, t, 30);
        end else begin
          p.red = chan(150, t, 105); p.green = p.red; p.blue = p.red;
        end
      end
      default: begin
        p.red = chan(0, t, 255);
        p.mono = 1'b1;
      end
    endcase
    return p;
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= 20) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [ChanW-1:0] got,
                             input logic [ChanW-1:0] want);
    if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // hold a stalled beat, else offer the next sample or idle
  always @(negedge clk_i) begin : feed
    logic v;
    logic [SampleW-1:0] d;
    v = in_valid_i;
    d = sample_i;
    if (!rst_ni) begin
      v = 1'b0;
    end else if (!in_valid_i || in_taken) begin
      v = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (samples_pending.size() != 0) begin
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(0, 4);
        end else begin
          v = 1'b1;
          d = samples_pending.pop_front();
        end
      end
    end
    in_valid_i <= v;
    sample_i <= d;
  end

  always @(negedge clk_i) begin : sink
    logic s;
    s = 1'b0;
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      s = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      s = 1'b1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 4);
      s = 1'b1;
    end
    out_stall_i <= s;
  end

  always @(posedge clk_i) begin : watch
    pixel_t want;
    if (!rst_ni) begin
      mode_shadow = MODE_GRAY;
      in_taken = 1'b0;
    end else begin
      if (cfg_we_i) mode_shadow = cfg_wdata_i;
      if (out_valid_o && !out_stall_i) begin
        if (pixels_due.size() == 0) begin
          report("pixel beat with nothing expected");
        end else begin
          want = pixels_due.pop_front();
          check_field("red", red_o, want.red);
          check_field("green", green_o, want.green);
          check_field("blue", blue_o, want.blue);
          check_field("mono", {7'd0, mono_o}, {7'd0, want.mono});
        end
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) pixels_due.push_back(map_sample(sample_i, mode_shadow));
    end
  end

  task automatic drain();
    int waited = 0;
    while ((samples_pending.size() != 0 || in_valid_i || pixels_due.size() != 0)
           && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (pixels_due.size() != 0 || samples_pending.size() != 0) begin
      report($sformatf("%0d pixels never arrived", pixels_due.size()));
      pixels_due.delete();
      samples_pending.delete();
    end
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [ModeW-1:0] m);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_t(input int unsigned t);
    samples_pending.push_back(16'(t) ^ 16'h8000);
  endtask

  function automatic logic [SampleW-1:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) return 16'($urandom);
    if (pick <= 8) return 16'(band_edges[$urandom_range(0, 7)] + $urandom_range(0, 6) - 3)
                          ^ 16'h8000;
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  initial begin : stimulus
    logic [ModeW-1:0] m;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    idle_pct = 25;
    set_mode(MODE_GRAY);
    samples_pending.push_back(16'h8000);
    samples_pending.push_back(16'h7fff);
    set_mode(MODE_RGB);
    samples_pending.push_back(16'h8000);
    samples_pending.push_back(16'h7fff);
    samples_pending.push_back(16'h0000);
    set_mode(MODE_RGBA);
    samples_pending.push_back(16'hffff);
    set_mode(MODE_HEIGHT);
    for (int i = 0; i < 4; i++) begin
      push_t(band_edges[i] - 1);
      push_t(band_edges[i]);
    end
    set_mode(MODE_TERRAIN);
    for (int i = 4; i < 8; i++) begin
      push_t(band_edges[i] - 1);
      push_t(band_edges[i]);
    end
    set_mode(MODE_RSVD5);
    samples_pending.push_back(16'h8000);
    samples_pending.push_back(16'h7fff);
    set_mode(MODE_RSVD6);
    samples_pending.push_back(16'h0000);
    set_mode(MODE_RSVD7);
    samples_pending.push_back(16'h5555);

    for (int ph = 0; ph < NumPhases; ph++) begin
      m = (ph < 8) ? mode_order[ph] : 3'($urandom_range(int'(MODE_GRAY), int'(MODE_RSVD7)));
      set_mode(m);
      case (ph % 4)
        0: idle_pct = 10;
        1: idle_pct = 30;
        2: idle_pct = 0;
        default: idle_pct = 55;
      endcase
      if (ph == NumPhases - 1) idle_pct = 0;
      if (ph == 4) hold_req = 1'b1;
      for (int k = 0; k < PhaseBeats; k++) samples_pending.push_back(rand_sample());
    end

    drain();
    if (errors == 0) begin
      $display("** noise_false_color_mapper_unit: PASSED **");
    end else begin
      $display("** noise_false_color_mapper_unit: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("** noise_false_color_mapper_unit: FAILED **");
    $finish;
  end

endmodule
